### design/ilt_pkg.sv
// Shared types and codes for the INI line tokenizer.
`default_nettype none
package ilt_pkg;

  localparam int DEF_MAX_TOKEN = 256;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_COMMENT = 3'd1;
  localparam logic [2:0] ST_SECTION = 3'd2;
  localparam logic [2:0] ST_KEY     = 3'd3;
  localparam logic [2:0] ST_PREVAL  = 3'd4;
  localparam logic [2:0] ST_VALUE   = 3'd5;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_SECTION = 3'd1;
  localparam logic [2:0] EV_KEY     = 3'd2;
  localparam logic [2:0] EV_VALUE   = 3'd3;
  localparam logic [2:0] EV_ERROR   = 3'd4;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_LONG    = 2'd1;
  localparam logic [1:0] ERR_SECTION = 2'd2;
  localparam logic [1:0] ERR_NOVALUE = 2'd3;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  typedef struct packed {
    logic        store_byte;
    logic [7:0]  store_index;
    logic [2:0]  event_kind;
    logic [8:0]  token_length;
    logic [1:0]  error_code;
    logic [15:0] line_number;
  } ilt_result_t;

endpackage
`default_nettype wire

### design/ini_line_tokenizer.sv
// Top level of the INI line tokenizer: state and result registers.
//
// Usage: feed the text one byte per beat on the in_ channel (in_valid,
// in_stall, in_byte_in). Every accepted byte yields exactly one result
// beat on the out_ channel: store flag and buffer index for the token
// byte, an event (section, key or value done, or error), the token
// length and the current line number.
// Latency: the result of a byte is presented in the cycle after it is
// accepted. Throughput: one byte per cycle while in_stall is low; parsing
// is a single combinational step between the state registers and the result register.
// Reset (rst_n low, synchronous) returns the parser to idle on line one,
// clears the token count and any latched error, and empties the result
// register. After an error every later byte returns the same error until
// reset.
// Stall: while a result waits with out_stall high, in_stall is raised and
// the result holds; a result that is taken frees the register for a new
// byte in the same cycle.
`default_nettype none
module ini_line_tokenizer #(
  parameter int MAX_TOKEN = ilt_pkg::DEF_MAX_TOKEN
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_store_byte,
  output logic [7:0]       out_store_index,
  output logic [2:0]       out_event_kind,
  output logic [8:0]       out_token_length,
  output logic [1:0]       out_error_code,
  output logic [15:0]      out_line_number
);
  import ilt_pkg::*;

  localparam int CW = $clog2(MAX_TOKEN + 1);

  logic [2:0]    parse_r, parse_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   line_r, line_nxt;
  logic          nl_r, nl_nxt;
  logic [1:0]    halt_r, halt_nxt;
  logic          out_valid_r;
  ilt_result_t   res_nxt, res_r;
  logic          accept;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  ilt_step #(
    .MAX_TOKEN(MAX_TOKEN)
  ) u_step (
    .byte_in            (in_byte_in),
    .parse_state        (parse_r),
    .token_count        (cnt_r),
    .line_count         (line_r),
    .newline_pending    (nl_r),
    .halted_error       (halt_r),
    .parse_state_nxt    (parse_nxt),
    .token_count_nxt    (cnt_nxt),
    .line_count_nxt     (line_nxt),
    .newline_pending_nxt(nl_nxt),
    .halted_error_nxt   (halt_nxt),
    .result             (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_r     <= ST_IDLE;
      cnt_r       <= '0;
      line_r      <= 16'd1;
      nl_r        <= 1'b0;
      halt_r      <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        parse_r     <= parse_nxt;
        cnt_r       <= cnt_nxt;
        line_r      <= line_nxt;
        nl_r        <= nl_nxt;
        halt_r      <= halt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_store_byte   = res_r.store_byte;
  assign out_store_index  = res_r.store_index;
  assign out_event_kind   = res_r.event_kind;
  assign out_token_length = res_r.token_length;
  assign out_error_code   = res_r.error_code;
  assign out_line_number  = res_r.line_number;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (halt_r != ERR_NONE) |=> (halt_r == $past(halt_r)))
    else $error("latched error changed before reset");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_TOKEN))
    else $error("token count beyond limit");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat produced no result");

  a_line_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (line_r >= $past(line_r)))
    else $error("line count went backward");

  a_error_coded: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.event_kind == EV_ERROR)) |-> (res_r.error_code != ERR_NONE))
    else $error("error event without code");

endmodule
`default_nettype wire

### design/ilt_step.sv
// Next-state and result logic for one byte of the INI line tokenizer.
`default_nettype none
module ilt_step #(
  parameter int MAX_TOKEN = ilt_pkg::DEF_MAX_TOKEN
) (
  input  wire logic [7:0]                       byte_in,
  input  wire logic [2:0]                       parse_state,
  input  wire logic [$clog2(MAX_TOKEN+1)-1:0]   token_count,
  input  wire logic [15:0]                      line_count,
  input  wire logic                             newline_pending,
  input  wire logic [1:0]                       halted_error,
  output logic      [2:0]                       parse_state_nxt,
  output logic      [$clog2(MAX_TOKEN+1)-1:0]   token_count_nxt,
  output logic      [15:0]                      line_count_nxt,
  output logic                                  newline_pending_nxt,
  output logic      [1:0]                       halted_error_nxt,
  output ilt_pkg::ilt_result_t                  result
);
  import ilt_pkg::*;

  localparam int CW = $clog2(MAX_TOKEN + 1);

  logic          eol;
  logic [CW+8:0] cnt_ext;
  logic [CW-1:0] cnt_inc;

  assign eol     = (byte_in == CH_CR) || (byte_in == CH_LF);
  assign cnt_ext = {9'd0, token_count};
  assign cnt_inc = token_count + CW'(1);

  always_comb begin
    parse_state_nxt     = parse_state;
    token_count_nxt     = token_count;
    line_count_nxt      = line_count;
    newline_pending_nxt = newline_pending;
    halted_error_nxt    = halted_error;
    result.store_byte   = 1'b0;
    result.store_index  = 8'd0;
    result.event_kind   = EV_NONE;
    result.token_length = 9'd0;
    result.error_code   = ERR_NONE;
    result.line_number  = line_count;

    if (halted_error != ERR_NONE) begin
      result.event_kind = EV_ERROR;
      result.error_code = halted_error;
    end else if (token_count >= CW'(MAX_TOKEN)) begin
      halted_error_nxt  = ERR_LONG;
      result.event_kind = EV_ERROR;
      result.error_code = ERR_LONG;
    end else begin
      if (newline_pending && (line_count != LINE_MAX)) begin
        line_count_nxt = line_count + 16'd1;
      end
      newline_pending_nxt = (byte_in == CH_LF);

      case (parse_state)
        ST_COMMENT: begin
          if (eol) begin
            parse_state_nxt = ST_IDLE;
          end
        end
        ST_SECTION: begin
          if ((byte_in == CH_LBRACK) || eol) begin
            result.event_kind = EV_ERROR;
            result.error_code = ERR_SECTION;
          end else if (byte_in == CH_RBRACK) begin
            parse_state_nxt     = ST_IDLE;
            result.event_kind   = EV_SECTION;
            result.token_length = cnt_ext[8:0];
          end else begin
            result.store_byte  = 1'b1;
            result.store_index = cnt_ext[7:0];
            token_count_nxt    = cnt_inc;
          end
        end
        ST_KEY: begin
          if (eol) begin
            result.event_kind = EV_ERROR;
            result.error_code = ERR_NOVALUE;
          end else if (byte_in == CH_EQUAL) begin
            parse_state_nxt     = ST_PREVAL;
            result.event_kind   = EV_KEY;
            result.token_length = cnt_ext[8:0];
          end else if (byte_in != CH_SPACE) begin
            result.store_byte  = 1'b1;
            result.store_index = cnt_ext[7:0];
            token_count_nxt    = cnt_inc;
          end
        end
        ST_PREVAL: begin
          token_count_nxt = '0;
          if (eol) begin
            parse_state_nxt   = ST_IDLE;
            result.event_kind = EV_VALUE;
          end else if (byte_in != CH_SPACE) begin
            parse_state_nxt   = ST_VALUE;
            result.store_byte = 1'b1;
            token_count_nxt   = CW'(1);
          end
        end
        ST_VALUE: begin
          if (eol) begin
            parse_state_nxt     = ST_IDLE;
            result.event_kind   = EV_VALUE;
            result.token_length = cnt_ext[8:0];
          end else begin
            result.store_byte  = 1'b1;
            result.store_index = cnt_ext[7:0];
            token_count_nxt    = cnt_inc;
          end
        end
        default: begin
          parse_state_nxt = ST_IDLE;
          token_count_nxt = '0;
          if (byte_in == CH_LBRACK) begin
            parse_state_nxt = ST_SECTION;
          end else if (byte_in == CH_HASH) begin
            parse_state_nxt = ST_COMMENT;
          end else if ((byte_in == CH_SPACE) || (byte_in == CH_TAB) || eol) begin
            parse_state_nxt = ST_IDLE;
          end else begin
            result.store_byte = 1'b1;
            token_count_nxt   = CW'(1);
            parse_state_nxt   = ST_KEY;
          end
        end
      endcase

      if (result.event_kind == EV_ERROR) begin
        halted_error_nxt = result.error_code;
      end
      result.line_number = line_count_nxt;
    end
  end

endmodule
`default_nettype wire

### bench/ilt_checker.sv
// Checker for the INI line tokenizer: tracks beats, predicts each result and compares it.
module ilt_checker #(
  parameter int MAX_TOKEN = ilt_pkg::DEF_MAX_TOKEN
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_store_byte,
  input  logic [7:0]  out_store_index,
  input  logic [2:0]  out_event_kind,
  input  logic [8:0]  out_token_length,
  input  logic [1:0]  out_error_code,
  input  logic [15:0] out_line_number,
  output int          fail_count,
  output int          pending_count
);
  import ilt_pkg::*;

  logic [2:0]  parse_st;
  int          tok_cnt;
  logic [15:0] line_cnt;
  logic        nl_pending;
  logic [1:0]  halt_err;
  ilt_result_t token_results_q[$];
  int          errs = 0;

  function automatic ilt_result_t tokenize_byte(input logic [7:0] c);
    ilt_result_t r;
    logic eol;
    r = '0;
    eol = (c == CH_CR) || (c == CH_LF);
    if (halt_err != ERR_NONE) begin
      r.event_kind = EV_ERROR;
      r.error_code = halt_err;
      r.line_number = line_cnt;
      return r;
    end
    if (tok_cnt >= MAX_TOKEN) begin
      halt_err = ERR_LONG;
      r.event_kind = EV_ERROR;
      r.error_code = ERR_LONG;
      r.line_number = line_cnt;
      return r;
    end
    if (nl_pending && line_cnt != LINE_MAX) line_cnt = line_cnt + 16'd1;
    nl_pending = (c == CH_LF);
    case (parse_st)
      ST_COMMENT: begin
        if (eol) parse_st = ST_IDLE;
      end
      ST_SECTION: begin
        if (c == CH_LBRACK || eol) begin
          r.event_kind = EV_ERROR;
          r.error_code = ERR_SECTION;
        end else if (c == CH_RBRACK) begin
          parse_st = ST_IDLE;
          r.event_kind = EV_SECTION;
          r.token_length = 9'(tok_cnt);
        end else begin
          r.store_byte = 1'b1;
          r.store_index = 8'(tok_cnt);
          tok_cnt++;
        end
      end
      ST_KEY: begin
        if (eol) begin
          r.event_kind = EV_ERROR;
          r.error_code = ERR_NOVALUE;
        end else if (c == CH_EQUAL) begin
          parse_st = ST_PREVAL;
          r.event_kind = EV_KEY;
          r.token_length = 9'(tok_cnt);
        end else if (c != CH_SPACE) begin
          r.store_byte = 1'b1;
          r.store_index = 8'(tok_cnt);
          tok_cnt++;
        end
      end
      ST_PREVAL: begin
        tok_cnt = 0;
        if (eol) begin
          parse_st = ST_IDLE;
          r.event_kind = EV_VALUE;
        end else if (c != CH_SPACE) begin
          parse_st = ST_VALUE;
          r.store_byte = 1'b1;
          tok_cnt = 1;
        end
      end
      ST_VALUE: begin
        if (eol) begin
          parse_st = ST_IDLE;
          r.event_kind = EV_VALUE;
          r.token_length = 9'(tok_cnt);
        end else begin
          r.store_byte = 1'b1;
          r.store_index = 8'(tok_cnt);
          tok_cnt++;
        end
      end
      default: begin
        parse_st = ST_IDLE;
        tok_cnt = 0;
        if (c == CH_LBRACK) begin
          parse_st = ST_SECTION;
        end else if (c == CH_HASH) begin
          parse_st = ST_COMMENT;
        end else if (!(c == CH_SPACE || c == CH_TAB || eol)) begin
          r.store_byte = 1'b1;
          tok_cnt = 1;
          parse_st = ST_KEY;
        end
      end
    endcase
    if (r.event_kind == EV_ERROR) halt_err = r.error_code;
    r.line_number = line_cnt;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin : track
    ilt_result_t want;
    if (!rst_n) begin
      parse_st = ST_IDLE;
      tok_cnt = 0;
      line_cnt = 16'd1;
      nl_pending = 1'b0;
      halt_err = ERR_NONE;
      token_results_q.delete();
    end else begin
      if (in_valid && !in_stall) token_results_q.push_back(tokenize_byte(in_byte_in));
      if (out_valid && !out_stall) begin
        if (token_results_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, got event %0d",
                   $time, out_event_kind);
          errs++;
        end else begin
          want = token_results_q.pop_front();
          check_field("store_byte", want.store_byte, out_store_byte);
          check_field("store_index", want.store_index, out_store_index);
          check_field("event_kind", want.event_kind, out_event_kind);
          check_field("token_length", want.token_length, out_token_length);
          check_field("error_code", want.error_code, out_error_code);
          check_field("line_number", want.line_number, out_line_number);
        end
      end
    end
    fail_count <= errs;
    pending_count <= token_results_q.size();
  end

endmodule

### bench/tb_top.sv
// Testbench top for the INI line tokenizer: clock, reset, text stimulus and verdict.
module tb_top;
  import ilt_pkg::*;

  localparam int TOKEN_CAP = DEF_MAX_TOKEN;

  typedef enum int {TXT_SECTION, TXT_KEY_HEAD, TXT_KEY, TXT_VALUE} text_kind_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte_in;
  logic        out_valid;
  logic        out_stall;
  logic        out_store_byte;
  logic [7:0]  out_store_index;
  logic [2:0]  out_event_kind;
  logic [8:0]  out_token_length;
  logic [1:0]  out_error_code;
  logic [15:0] out_line_number;
  int          fail_count;
  int          pending_count;

  int sent_bytes = 0;
  bit tx_idle_on = 1'b0;
  bit line_calm = 1'b0;
  bit rx_idle_on = 1'b0;
  int rx_hold_left = 0;
  int rx_burst_left = 0;
  int rx_quiet_left = 0;

  ini_line_tokenizer #(.MAX_TOKEN(TOKEN_CAP)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte_in(in_byte_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_store_byte(out_store_byte), .out_store_index(out_store_index),
    .out_event_kind(out_event_kind), .out_token_length(out_token_length),
    .out_error_code(out_error_code), .out_line_number(out_line_number)
  );

  ilt_checker #(.MAX_TOKEN(TOKEN_CAP)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte_in(in_byte_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_store_byte(out_store_byte), .out_store_index(out_store_index),
    .out_event_kind(out_event_kind), .out_token_length(out_token_length),
    .out_error_code(out_error_code), .out_line_number(out_line_number),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_stall <= 1'b1;
        rx_hold_left--;
      end else if (!rx_idle_on || rx_quiet_left > 0) begin
        out_stall <= 1'b0;
        if (rx_quiet_left > 0) rx_quiet_left--;
      end else if (rx_burst_left > 0) begin
        out_stall <= 1'b1;
        rx_burst_left--;
      end else begin
        case ($urandom_range(0, 15))
          0, 1, 2: begin
            out_stall <= 1'b1;
            rx_burst_left = $urandom_range(0, 10);
          end
          3: begin
            out_stall <= 1'b0;
            rx_quiet_left = $urandom_range(20, 80);
          end
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  function automatic logic [7:0] pick_byte(input text_kind_e kind);
    logic [7:0] b;
    bit ok;
    ok = 1'b0;
    b = 8'd0;
    while (!ok) begin
      b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
      ok = (b != CH_CR) && (b != CH_LF);
      case (kind)
        TXT_SECTION:  ok = ok && b != CH_LBRACK && b != CH_RBRACK;
        TXT_KEY_HEAD: ok = ok && b != CH_SPACE && b != CH_TAB && b != CH_LBRACK && b != CH_HASH;
        TXT_KEY:      ok = ok && b != CH_EQUAL;
        default: ;
      endcase
    end
    return b;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 149);
    if (r == 0) return 255;
    if (r < 4) return $urandom_range(100, 254);
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [7:0] pick_ws();
    return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (tx_idle_on && !line_calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_in <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_eol();
    case ($urandom_range(0, 2))
      0: send_byte(CH_CR);
      1: send_byte(CH_LF);
      default: begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
    endcase
  endtask

  task automatic send_section_line();
    send_byte(CH_LBRACK);
    repeat (pick_len()) send_byte(pick_byte(TXT_SECTION));
    send_byte(CH_RBRACK);
    repeat ($urandom_range(0, 1)) send_byte(pick_ws());
    send_eol();
  endtask

  task automatic send_pair_line(input bit longest);
    int n;
    n = pick_len();
    if (n == 0) n = 1;
    repeat ($urandom_range(0, 2)) send_byte(pick_ws());
    send_byte(pick_byte(TXT_KEY_HEAD));
    repeat (n - 1) send_byte(pick_byte(TXT_KEY));
    if ($urandom_range(0, 3) == 0) send_byte(CH_SPACE);
    send_byte(CH_EQUAL);
    repeat ($urandom_range(0, 2)) send_byte(CH_SPACE);
    if (longest) begin
      send_byte(pick_byte(TXT_KEY_HEAD));
      repeat (254) send_byte(pick_byte(TXT_VALUE));
    end else begin
      repeat (pick_len()) send_byte(pick_byte(TXT_VALUE));
    end
    send_eol();
  endtask

  task automatic send_comment_line();
    repeat ($urandom_range(0, 2)) send_byte(pick_ws());
    send_byte(CH_HASH);
    repeat (pick_len()) send_byte(pick_byte(TXT_VALUE));
    send_eol();
  endtask

  task automatic send_blank_line();
    repeat ($urandom_range(0, 3)) send_byte(pick_ws());
    send_eol();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin : stimulus
    int start;
    int pick;
    bit held;
    bit paused;
    logic [1:0] err_pick;
    held = 1'b0;
    paused = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_byte_in <= 8'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_str("[]");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_str("#x");
    send_byte(CH_LF);
    send_str("  k y =  v");
    send_byte(CH_TAB);
    send_str("1");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_TAB);
    send_str("z=");
    send_byte(CH_LF);
    drain();

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    start = sent_bytes;
    while (sent_bytes - start < 1100) begin
      line_calm = ($urandom_range(0, 3) == 0);
      if (!held && sent_bytes - start > 350) begin
        held = 1'b1;
        line_calm = 1'b1;
        rx_hold_left = 200;
      end
      if (!paused && sent_bytes - start > 700) begin
        paused = 1'b1;
        drain();
        send_pair_line(1'b1);
      end
      pick = $urandom_range(0, 19);
      if (pick < 10) send_pair_line(1'b0);
      else if (pick < 14) send_section_line();
      else if (pick < 17) send_comment_line();
      else send_blank_line();
    end

    // close on three blank lines and a section line, then end on an error
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (3) send_byte(CH_LF);
    send_str("[s]");
    send_byte(CH_LF);
    err_pick = 2'($urandom_range(1, 3));
    case (err_pick)
      ERR_LONG: begin
        send_byte(CH_LBRACK);
        repeat (TOKEN_CAP) send_byte(pick_byte(TXT_SECTION));
      end
      ERR_SECTION: begin
        send_byte(CH_LBRACK);
        send_str("ab");
        case ($urandom_range(0, 2))
          0: send_byte(CH_LBRACK);
          1: send_byte(CH_CR);
          default: send_byte(CH_LF);
        endcase
      end
      default: begin
        send_byte(pick_byte(TXT_KEY_HEAD));
        send_str("q r");
        send_eol();
      end
    endcase
    repeat (8) send_byte(8'($urandom_range(0, 255)));
    drain();
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### ini_line_tokenizer.f
design/ilt_pkg.sv
design/ilt_step.sv
design/ini_line_tokenizer.sv
bench/ilt_checker.sv
bench/tb_top.sv
